FILE: rtl/mairpq_pkg.sv
// Shared constants and types for the multi-arm infrared position qualifier.
`default_nettype none

package mairpq_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int THR_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam int NUM_POS     = 5;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_W        = 14;
  localparam int IN_BYTES_W  = 16;
  localparam int RES_W       = 12;
  localparam int RES_BYTES_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM0_THR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR     = 2'd2;

  localparam logic [THR_W-1:0] ARM0_THR_RST = 16'd1250;
  localparam logic [THR_W-1:0] SIDE_THR_RST = 16'd750;

  localparam logic [1:0] REL_NONE = 2'd0;
  localparam logic [1:0] REL_ARM0 = 2'd1;
  localparam logic [1:0] REL_ARM1 = 2'd2;
  localparam logic [1:0] REL_ARM2 = 2'd3;

  typedef struct packed {
    logic en;
    logic release_mode;
    logic iclr;
  } arm_ctrl_t;

  typedef struct packed {
    logic             changed;
    logic             released;
    logic [POS_W-1:0] pos_d;
  } arm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mairpq_arm.sv
// One arm: position counters, threshold qualification and release tracking.
`default_nettype none

module mairpq_arm (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire mairpq_pkg::arm_ctrl_t                  ctrl_i,
  input  wire logic [mairpq_pkg::NUM_POS-1:0]         inc_i,
  input  wire logic [mairpq_pkg::NUM_POS-1:0]         zero_i,
  input  wire logic                                   first_i,
  input  wire logic [mairpq_pkg::THR_W-1:0]           thr_i,
  output mairpq_pkg::arm_stat_t                       stat_o
);

  logic [mairpq_pkg::COUNT_WIDTH-1:0] cnt_q   [mairpq_pkg::NUM_POS];
  logic [mairpq_pkg::COUNT_WIDTH-1:0] cnt_d   [mairpq_pkg::NUM_POS];
  logic [mairpq_pkg::COUNT_WIDTH-1:0] cnt_upd [mairpq_pkg::NUM_POS];
  logic [mairpq_pkg::NUM_POS-1:0]     hit;
  logic [mairpq_pkg::POS_W-1:0]       sel;
  logic [mairpq_pkg::POS_W-1:0]       cur_q, cur_d;
  logic [mairpq_pkg::POS_W-1:0]       rep_q, rep_d;
  logic                               thr_zero;
  logic                               changed;
  logic                               released;

  always_comb begin
    logic [mairpq_pkg::COUNT_WIDTH-1:0] base;
    base = '0;
    for (int p = 0; p < mairpq_pkg::NUM_POS; p++) begin
      base = ctrl_i.iclr ? '0 : cnt_q[p];
      if (inc_i[p]) begin
        cnt_upd[p] = (base == {mairpq_pkg::COUNT_WIDTH{1'b1}}) ? base : base + 1'b1;
      end else if (zero_i[p]) begin
        cnt_upd[p] = '0;
      end else begin
        cnt_upd[p] = base;
      end
      hit[p] = mairpq_pkg::CMP_W'(cnt_upd[p]) >= mairpq_pkg::CMP_W'(thr_i);
    end
  end

  // With a zero threshold every position qualifies and the lowest one is taken last.
  always_comb begin
    thr_zero = (thr_i == '0);
    sel      = '0;
    for (int p = 0; p < mairpq_pkg::NUM_POS; p++) begin
      if (hit[p]) begin
        sel = mairpq_pkg::POS_W'(p);
      end
    end
    if (thr_zero) begin
      sel = '0;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    rep_d    = rep_q;
    changed  = 1'b0;
    released = 1'b0;
    if (ctrl_i.en) begin
      if (ctrl_i.release_mode) begin
        if (cur_q == '0) begin
          if (!first_i) begin
            cur_d = mairpq_pkg::POS_W'(1);
          end
        end else if (cur_q == mairpq_pkg::POS_W'(1)) begin
          if (first_i) begin
            cur_d    = '0;
            released = 1'b1;
            changed  = 1'b1;
          end
        end
      end else begin
        cnt_d = cnt_upd;
        if (|hit) begin
          for (int p = 0; p < mairpq_pkg::NUM_POS; p++) begin
            cnt_d[p] = '0;
          end
          cur_d   = sel;
          rep_d   = sel;
          changed = thr_zero || (rep_q != sel);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < mairpq_pkg::NUM_POS; p++) begin
        cnt_q[p] <= '0;
      end
      cur_q <= '0;
      rep_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      rep_q <= rep_d;
    end
  end

  assign stat_o.changed  = changed;
  assign stat_o.released = released;
  assign stat_o.pos_d    = rep_d;

endmodule

`default_nettype wire

FILE: rtl/multi_arm_ir_position_qualifier.sv
// Top level of the multi-arm infrared position qualifier.
//
// Input stream: each word is one sample of the sensor levels of three arms,
// plus a hold flag and an interval-clear flag. Every accepted word produces
// exactly one result word on the output stream: a change flag, the accepted
// position of each arm and, in free-way mode, the released arm.
// The configuration port writes the mode and the two thresholds; it must be
// written only while no word is in flight; the block itself does not enforce this.
// A sample is captured in an input register; when it advances, all counters,
// comparisons and position updates are done in one step and the result is
// loaded into the output register. One word is accepted every cycle while the
// receiver keeps up.
// When the receiver stalls, the result register holds its word, the input
// register keeps one more sample, and tready drops only when both are full.
// Reset clears all counters and positions, sets free-way mode off and loads
// thresholds of 1250 for arm 0 and 750 for arms 1 and 2.
`default_nettype none

module multi_arm_ir_position_qualifier (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [mairpq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mairpq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // hold, interval_clear, arm0_bits[1:0], arm1_bits[4:0], arm2_bits[4:0], zero pad.
  input  wire logic [mairpq_pkg::IN_BYTES_W-1:0]      s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // changed, pos_arm0[2:0], pos_arm1[2:0], pos_arm2[2:0], released_arm[1:0], zero pad.
  output logic [mairpq_pkg::RES_BYTES_W-1:0]          m_axis_tdata_o
);

  logic                               release_mode_q;
  logic [mairpq_pkg::THR_W-1:0]       arm0_thr_q;
  logic [mairpq_pkg::THR_W-1:0]       side_thr_q;
  logic                               in_valid_q;
  logic [mairpq_pkg::IN_W-1:0]        in_data_q;
  logic                               out_valid_q;
  logic [mairpq_pkg::RES_W-1:0]       res_q, res_d;
  logic                               adv;
  logic                               hold;
  logic                               iclr;
  logic [1:0]                         arm0_bits;
  logic [mairpq_pkg::NUM_POS-1:0]     arm1_bits;
  logic [mairpq_pkg::NUM_POS-1:0]     arm2_bits;
  logic [mairpq_pkg::NUM_POS-1:0]     inc0, inc1, inc2;
  logic [mairpq_pkg::NUM_POS-1:0]     zero0;
  logic [1:0]                         rel;
  mairpq_pkg::arm_ctrl_t              ctrl;
  mairpq_pkg::arm_stat_t              stat0, stat1, stat2;

  function automatic logic [mairpq_pkg::NUM_POS-1:0] first_low(
    input logic [mairpq_pkg::NUM_POS-1:0] bits
  );
    logic [mairpq_pkg::NUM_POS-1:0] hot;
    logic                           found;
    hot   = '0;
    found = 1'b0;
    for (int p = 0; p < mairpq_pkg::NUM_POS; p++) begin
      hot[p] = !bits[p] && !found;
      found  = found || !bits[p];
    end
    return hot;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_mode_q <= 1'b0;
      arm0_thr_q     <= mairpq_pkg::ARM0_THR_RST;
      side_thr_q     <= mairpq_pkg::SIDE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mairpq_pkg::CFG_RELEASE_MODE: release_mode_q <= cfg_data_i[0];
        mairpq_pkg::CFG_ARM0_THR: arm0_thr_q <= cfg_data_i;
        mairpq_pkg::CFG_SIDE_THR: side_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i[mairpq_pkg::IN_W-1:0];
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign hold      = in_data_q[0];
  assign iclr      = in_data_q[1];
  assign arm0_bits = in_data_q[3:2];
  assign arm1_bits = in_data_q[8:4];
  assign arm2_bits = in_data_q[13:9];

  assign inc0  = {3'b000, arm0_bits};
  assign zero0 = {3'b000, ~arm0_bits};
  assign inc1  = first_low(arm1_bits);
  assign inc2  = first_low(arm2_bits);

  assign ctrl.en           = adv && !hold;
  assign ctrl.release_mode = release_mode_q;
  assign ctrl.iclr         = iclr;

  mairpq_arm u_arm0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .inc_i   (inc0),
    .zero_i  (zero0),
    .first_i (arm0_bits[0]),
    .thr_i   (arm0_thr_q),
    .stat_o  (stat0)
  );

  mairpq_arm u_arm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .inc_i   (inc1),
    .zero_i  ('0),
    .first_i (arm1_bits[0]),
    .thr_i   (side_thr_q),
    .stat_o  (stat1)
  );

  mairpq_arm u_arm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .inc_i   (inc2),
    .zero_i  ('0),
    .first_i (arm2_bits[0]),
    .thr_i   (side_thr_q),
    .stat_o  (stat2)
  );

  always_comb begin
    if (stat2.released) begin
      rel = mairpq_pkg::REL_ARM2;
    end else if (stat1.released) begin
      rel = mairpq_pkg::REL_ARM1;
    end else if (stat0.released) begin
      rel = mairpq_pkg::REL_ARM0;
    end else begin
      rel = mairpq_pkg::REL_NONE;
    end
  end

  assign res_d = {rel, stat2.pos_d, stat1.pos_d, stat0.pos_d,
                  stat0.changed || stat1.changed || stat2.changed};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(mairpq_pkg::RES_BYTES_W - mairpq_pkg::RES_W){1'b0}}, res_q};

  // A held sample never reports a change or a release.
  a_hold_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && hold) |=> (res_q[0] == 1'b0 && res_q[11:10] == mairpq_pkg::REL_NONE))
    else $error("held sample reported a change");

  // Counted mode never reports a release.
  a_counted_no_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !release_mode_q) |=> (res_q[11:10] == mairpq_pkg::REL_NONE))
    else $error("release reported in counted mode");

  // A release always comes with the change flag.
  a_rel_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && rel != mairpq_pkg::REL_NONE) |-> res_d[0])
    else $error("release without change flag");

  // Input backpressure only while both registers are full and the output stalls.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

FILE: bench/multi_arm_ir_position_qualifier_checker.sv
// Checker that watches both streams and the register port, predicts every result word and compares.
module multi_arm_ir_position_qualifier_checker
  import mairpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_BYTES_W-1:0] s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [RES_BYTES_W-1:0] m_tdata_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    changes_o,
  output int                    releases_o
);

  localparam int NUM_ARMS = 3;
  localparam logic [POS_W-1:0] ARMED    = 3'd0;
  localparam logic [POS_W-1:0] SEEN_LOW = 3'd1;

  typedef struct packed {
    logic             changed;
    logic [POS_W-1:0] arm0;
    logic [POS_W-1:0] arm1;
    logic [POS_W-1:0] arm2;
    logic [1:0]       rel;
  } qual_result_t;

  logic                   release_mode;
  logic [THR_W-1:0]       arm0_thr;
  logic [THR_W-1:0]       side_thr;
  logic [COUNT_WIDTH-1:0] tally [NUM_ARMS][NUM_POS];
  logic [POS_W-1:0]       cur_pos [NUM_ARMS];
  logic [POS_W-1:0]       shown_pos [NUM_ARMS];
  qual_result_t           expected_results [$];
  qual_result_t           want;
  qual_result_t           got;

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    results_o  = 0;
    changes_o  = 0;
    releases_o = 0;
  end

  function automatic logic [1:0] rel_code(input int a);
    case (a)
      0:       return REL_ARM0;
      1:       return REL_ARM1;
      default: return REL_ARM2;
    endcase
  endfunction

  function automatic void bump(input int a, input int p);
    if (tally[a][p] != '1) tally[a][p] = tally[a][p] + 1'b1;
  endfunction

  // Positions are scanned from the highest index down; one that has reached the
  // threshold clears the arm and is accepted, so the highest such index wins, or zero with a zero threshold.
  function automatic logic settle_arm(input int a, input logic [THR_W-1:0] thr);
    logic moved;
    moved = 1'b0;
    for (int p = NUM_POS - 1; p >= 0; p--) begin
      if (CMP_W'(tally[a][p]) >= CMP_W'(thr)) begin
        for (int k = 0; k < NUM_POS; k++) tally[a][k] = '0;
        cur_pos[a] = POS_W'(p);
        if (shown_pos[a] != cur_pos[a]) begin
          shown_pos[a] = cur_pos[a];
          moved = 1'b1;
        end
      end
    end
    return moved;
  endfunction

  function automatic qual_result_t qualify_sample(input logic [IN_BYTES_W-1:0] w);
    logic         hold;
    logic         iclr;
    logic [1:0]   a0;
    logic [4:0]   a1;
    logic [4:0]   a2;
    logic [2:0]   first;
    logic [4:0]   side;
    qual_result_t r;
    hold = w[0];
    iclr = w[1];
    a0 = w[3:2];
    a1 = w[8:4];
    a2 = w[13:9];
    r.changed = 1'b0;
    r.rel = REL_NONE;
    if (!hold) begin
      if (release_mode) begin
        first = {a2[0], a1[0], a0[0]};
        for (int a = 0; a < NUM_ARMS; a++) begin
          if (cur_pos[a] == ARMED) begin
            if (!first[a]) cur_pos[a] = SEEN_LOW;
          end else if (cur_pos[a] == SEEN_LOW && first[a]) begin
            cur_pos[a] = ARMED;
            r.rel = rel_code(a);
            r.changed = 1'b1;
          end
        end
      end else begin
        if (iclr) begin
          for (int a = 0; a < NUM_ARMS; a++)
            for (int p = 0; p < NUM_POS; p++) tally[a][p] = '0;
        end
        if (a0[0]) bump(0, 0); else tally[0][0] = '0;
        if (a0[1]) bump(0, 1); else tally[0][1] = '0;
        if (settle_arm(0, arm0_thr)) r.changed = 1'b1;
        for (int a = 1; a < NUM_ARMS; a++) begin
          side = (a == 1) ? a1 : a2;
          for (int p = 0; p < NUM_POS; p++) begin
            if (!side[p]) begin
              bump(a, p);
              break;
            end
          end
          if (settle_arm(a, side_thr)) r.changed = 1'b1;
        end
      end
    end
    r.arm0 = shown_pos[0];
    r.arm1 = shown_pos[1];
    r.arm2 = shown_pos[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    errors_o++;
    $display("MISMATCH %s: expected %0d, got %0d (result word %0d)",
             what, want_v, got_v, results_o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_mode = 1'b0;
      arm0_thr = ARM0_THR_RST;
      side_thr = SIDE_THR_RST;
      for (int a = 0; a < NUM_ARMS; a++) begin
        for (int p = 0; p < NUM_POS; p++) tally[a][p] = '0;
        cur_pos[a] = '0;
        shown_pos[a] = '0;
      end
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RELEASE_MODE: release_mode = cfg_data_i[0];
          CFG_ARM0_THR: arm0_thr = cfg_data_i[THR_W-1:0];
          CFG_SIDE_THR: side_thr = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expected_results.push_back(qualify_sample(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = qual_result_t'({m_tdata_i[0], m_tdata_i[3:1], m_tdata_i[6:4],
                              m_tdata_i[9:7], m_tdata_i[11:10]});
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 0, 32'(m_tdata_i));
        end else begin
          want = expected_results.pop_front();
          if (got.changed != want.changed)
            report_mismatch("changed", 32'(want.changed), 32'(got.changed));
          if (got.arm0 != want.arm0)
            report_mismatch("pos_arm0", 32'(want.arm0), 32'(got.arm0));
          if (got.arm1 != want.arm1)
            report_mismatch("pos_arm1", 32'(want.arm1), 32'(got.arm1));
          if (got.arm2 != want.arm2)
            report_mismatch("pos_arm2", 32'(want.arm2), 32'(got.arm2));
          if (got.rel != want.rel)
            report_mismatch("released_arm", 32'(want.rel), 32'(got.rel));
          results_o++;
          if (want.changed) changes_o++;
          if (want.rel != REL_NONE) releases_o++;
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: bench/multi_arm_ir_position_qualifier_tb.sv
// Testbench top that drives samples and register writes into the qualifier and gives the verdict.
module multi_arm_ir_position_qualifier_tb;
  import mairpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 80;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_RELEASE_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic [IN_BYTES_W-1:0]  s_tdata = '0;
  logic                   m_tready = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [RES_BYTES_W-1:0] m_tdata;

  int   errors;
  int   pending;
  int   results;
  int   changes;
  int   releases;
  int   samples_sent = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   quiet_cycles = 0;
  int   hold_off_left = 0;
  logic hold_off_done = 1'b0;
  logic long_stall_req = 1'b0;

  multi_arm_ir_position_qualifier dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  multi_arm_ir_position_qualifier_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .changes_o  (changes),
    .releases_o (releases)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else if (long_stall_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_off_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("multi_arm_ir_position_qualifier verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [IN_BYTES_W-1:0] pack_sample(input logic hold, input logic iclr,
                                                        input logic [1:0] a0,
                                                        input logic [4:0] a1,
                                                        input logic [4:0] a2);
    return {2'b00, a2, a1, a0, iclr, hold};
  endfunction

  // Sensor bits whose first low level sits at the given position; five means none low.
  function automatic logic [4:0] side_bits(input int pos);
    logic [4:0] b;
    b = 5'($urandom);
    for (int i = 0; i < 5; i++) begin
      if (i < pos) b[i] = 1'b1;
      else if (i == pos) b[i] = 1'b0;
    end
    return b;
  endfunction

  task automatic push_sample(input logic [IN_BYTES_W-1:0] w);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk_i); while (!s_tready);
    samples_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic fw, input logic [THR_W-1:0] t0,
                                input logic [THR_W-1:0] t1);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_RELEASE_MODE;
    cfg_data <= CFG_DATA_W'(fw);
    @(posedge clk_i);
    cfg_idx <= CFG_ARM0_THR;
    cfg_data <= t0;
    @(posedge clk_i);
    cfg_idx <= CFG_SIDE_THR;
    cfg_data <= t1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct <= rcv;
  endtask

  // Mostly steady sensor runs so counters reach their thresholds, mixed with noise.
  task automatic run_counted(input int n, input int max_run);
    int         left;
    int         run;
    int         p1;
    int         p2;
    logic [1:0] a0;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 12) begin
        push_sample(pack_sample(1'($urandom), 1'($urandom), 2'($urandom), 5'($urandom),
                                5'($urandom)));
        left--;
      end else begin
        run = $urandom_range(1, max_run);
        a0 = 2'($urandom);
        p1 = $urandom_range(5);
        p2 = $urandom_range(5);
        for (int i = 0; i < run && left > 0; i++) begin
          push_sample(pack_sample($urandom_range(99) < 5, $urandom_range(99) < 3, a0,
                                  side_bits(p1), side_bits(p2)));
          left--;
        end
      end
    end
  endtask

  task automatic run_release_mode(input int n);
    logic [2:0] lvl;
    logic [1:0] a0;
    logic [4:0] a1;
    logic [4:0] a2;
    lvl = 3'($urandom);
    for (int i = 0; i < n; i++) begin
      lvl = lvl ^ (3'($urandom) & 3'($urandom));
      a0 = 2'($urandom);
      a1 = 5'($urandom);
      a2 = 5'($urandom);
      a0[0] = lvl[0];
      a1[0] = lvl[1];
      a2[0] = lvl[2];
      push_sample(pack_sample($urandom_range(99) < 6, 1'($urandom), a0, a1, a2));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(1'b0, 16'd2, 16'd2);
    push_sample(pack_sample(1'b0, 1'b0, 2'b00, 5'b00000, 5'b00000));
    push_sample(pack_sample(1'b0, 1'b0, 2'b00, 5'b00000, 5'b00000));
    push_sample(pack_sample(1'b0, 1'b0, 2'b11, 5'b11101, 5'b01111));
    push_sample(pack_sample(1'b0, 1'b0, 2'b11, 5'b11101, 5'b01111));
    push_sample(pack_sample(1'b1, 1'b1, 2'b10, 5'b11111, 5'b11111));
    push_sample(pack_sample(1'b0, 1'b0, 2'b10, 5'b11111, 5'b11111));
    push_sample(pack_sample(1'b0, 1'b1, 2'b10, 5'b10111, 5'b11011));
    push_sample(pack_sample(1'b0, 1'b0, 2'b10, 5'b10111, 5'b11011));
    push_sample(pack_sample(1'b0, 1'b0, 2'b11, 5'b11111, 5'b11111));

    apply_settings(1'b1, 16'd2, 16'd2);
    push_sample(pack_sample(1'b0, 1'b1, 2'b10, 5'b11110, 5'b11110));
    push_sample(pack_sample(1'b1, 1'b0, 2'b11, 5'b11111, 5'b11111));
    push_sample(pack_sample(1'b0, 1'b0, 2'b01, 5'b00001, 5'b00001));
    push_sample(pack_sample(1'b0, 1'b0, 2'b00, 5'b00000, 5'b00000));
    push_sample(pack_sample(1'b0, 1'b0, 2'b01, 5'b00000, 5'b00000));
    push_sample(pack_sample(1'b0, 1'b0, 2'b00, 5'b00001, 5'b00000));
    push_sample(pack_sample(1'b0, 1'b1, 2'b01, 5'b00001, 5'b00001));

    apply_settings(1'b0, 16'd0, 16'd0);
    push_sample(pack_sample(1'b0, 1'b0, 2'b00, 5'b11111, 5'b11111));
    push_sample(pack_sample(1'b0, 1'b1, 2'b11, 5'b01111, 5'b11110));
    push_sample(pack_sample(1'b1, 1'b0, 2'b01, 5'b11011, 5'b00000));

    apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
    push_sample(pack_sample(1'b0, 1'b0, 2'b11, 5'b00000, 5'b01111));
    push_sample(pack_sample(1'b0, 1'b0, 2'b11, 5'b00000, 5'b01111));

    set_idling(24, 60);
    apply_settings(1'b0, 16'd1, 16'd1);
    run_counted(250, 3);
    apply_settings(1'b1, 16'd1, 16'd1);
    run_release_mode(250);

    set_idling(60, 24);
    apply_settings(1'b0, 16'd3, 16'd5);
    run_counted(300, 8);
    apply_settings(1'b0, 16'd0, 16'hFFFF);
    run_counted(150, 6);
    apply_settings(1'b1, 16'd7, 16'd2);
    run_release_mode(200);

    set_idling(0, 0);
    apply_settings(1'b0, 16'hFFFF, 16'd1);
    run_counted(150, 4);
    apply_settings(1'b0, THR_W'($urandom_range(1, 8)), THR_W'($urandom_range(1, 8)));
    long_stall_req <= 1'b1;
    run_counted(480, 11);

    drain();
    $display("Sent %0d samples through counted and free-way modes, thresholds 0 to 65535,",
             samples_sent);
    $display("with hold and interval clear; %0d results checked, %0d changes, %0d releases.",
             results, changes, releases);
    if (errors == 0 && pending == 0) begin
      $display("multi_arm_ir_position_qualifier verification clean");
    end else begin
      $display("multi_arm_ir_position_qualifier verification failed");
    end
    $finish;
  end

endmodule
